// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level RTL file of the packet deframer.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/rspd_pkg.sv
// Package for the packet deframer: phase and event codes, protocol characters,
// the result record type and the hex digit decoder. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rspd_pkg;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_ESCAPE   = 3'd2;
	localparam logic [2:0] PH_RUNLEN   = 3'd3;
	localparam logic [2:0] PH_END      = 3'd4;
	localparam logic [2:0] PH_CHECKSUM = 3'd5;

	localparam logic [1:0] EV_DATA       = 2'd0;
	localparam logic [1:0] EV_END        = 2'd1;
	localparam logic [1:0] EV_BREAK      = 2'd2;
	localparam logic [1:0] EV_UNEXPECTED = 2'd3;

	localparam logic [7:0] CH_DOLLAR     = 8'h24;
	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_BREAK      = 8'h03;
	localparam logic [7:0] MAX_BODY_CHAR = 8'd126;
	localparam logic [7:0] ESC_MASK      = 8'h20;
	localparam logic [7:0] RUN_BIAS      = 8'd29;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] count;
		logic       ok;
	} rspd_result_t;

	// Returns a valid flag in the top bit and the digit value below it.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rspd_parser.sv
// Deframing state machine: phase, running sum, checksum digit and last body byte.
// Processes one byte per enabled cycle and yields at most one result. Uses rspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rspd_parser
	import rspd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx_byte,
	output logic              emit,
	output rspd_result_t      res
);

	logic [2:0] phase_q;
	logic [7:0] sum_q;
	logic [3:0] nibble_q;
	logic [7:0] last_q;
	logic       nonempty_q;

	logic [2:0] phase_d;
	logic [7:0] sum_d;
	logic [3:0] nibble_d;
	logic [7:0] last_d;
	logic       nonempty_d;

	logic [4:0] hex;
	logic [7:0] esc_byte;
	logic [7:0] run_len;
	logic       sum_add;

	always_comb begin
		hex      = hex_decode(rx_byte);
		esc_byte = rx_byte ^ ESC_MASK;
		run_len  = (rx_byte >= RUN_BIAS) ? (rx_byte - RUN_BIAS) : 8'd0;
		sum_add  = (phase_q == PH_BODY && rx_byte != CH_HASH) ||
		           phase_q == PH_ESCAPE || phase_q == PH_RUNLEN;

		phase_d    = phase_q;
		sum_d      = sum_add ? 8'(sum_q + rx_byte) : sum_q;
		nibble_d   = nibble_q;
		last_d     = last_q;
		nonempty_d = nonempty_q;
		emit       = 1'b0;
		res        = '{kind: EV_DATA, data: 8'd0, count: 8'd0, ok: 1'b0};

		unique case (phase_q)
			PH_BODY: begin
				if (rx_byte == CH_RBRACE) begin
					phase_d = PH_ESCAPE;
				end else if (rx_byte == CH_HASH) begin
					phase_d = PH_END;
				end else if (rx_byte == CH_STAR) begin
					phase_d = PH_RUNLEN;
				end else if (rx_byte > MAX_BODY_CHAR) begin
					emit     = 1'b1;
					res.kind = EV_UNEXPECTED;
					res.data = rx_byte;
				end else begin
					last_d     = rx_byte;
					nonempty_d = 1'b1;
					emit       = 1'b1;
					res.data   = rx_byte;
					res.count  = 8'd1;
				end
			end
			PH_ESCAPE: begin
				last_d     = esc_byte;
				nonempty_d = 1'b1;
				phase_d    = PH_BODY;
				emit       = 1'b1;
				res.data   = esc_byte;
				res.count  = 8'd1;
			end
			PH_RUNLEN: begin
				phase_d = PH_BODY;
				if (nonempty_q && run_len != 8'd0) begin
					emit      = 1'b1;
					res.data  = last_q;
					res.count = run_len;
				end
			end
			PH_END: begin
				if (hex[4]) begin
					nibble_d = hex[3:0];
					phase_d  = PH_CHECKSUM;
				end else begin
					emit     = 1'b1;
					res.kind = EV_UNEXPECTED;
					res.data = rx_byte;
				end
			end
			PH_CHECKSUM: begin
				emit = 1'b1;
				if (hex[4]) begin
					res.kind   = EV_END;
					res.ok     = ({nibble_q, hex[3:0]} == sum_q);
					phase_d    = PH_IDLE;
					sum_d      = 8'd0;
					nibble_d   = 4'd0;
					last_d     = 8'd0;
					nonempty_d = 1'b0;
				end else begin
					res.kind = EV_UNEXPECTED;
					res.data = rx_byte;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
					emit = 1'b0;
				end else if (rx_byte == CH_DOLLAR) begin
					phase_d = PH_BODY;
				end else if (rx_byte == CH_BREAK) begin
					emit     = 1'b1;
					res.kind = EV_BREAK;
				end else begin
					emit     = 1'b1;
					res.kind = EV_UNEXPECTED;
					res.data = rx_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			sum_q      <= 8'd0;
			nibble_q   <= 4'd0;
			last_q     <= 8'd0;
			nonempty_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			sum_q      <= sum_d;
			nibble_q   <= nibble_d;
			last_q     <= last_d;
			nonempty_q <= nonempty_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rspd_out_reg.sv
// Result register of the deframer: holds one result beat until the consumer takes it.
// Uses rspd_result_t from rspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rspd_out_reg
	import rspd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire rspd_result_t res,
	output logic              free,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        event_kind,
	output logic [7:0]        data_byte,
	output logic [7:0]        repeat_count,
	output logic              checksum_ok
);

	logic         valid_q;
	rspd_result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign event_kind   = res_q.kind;
	assign data_byte    = res_q.data;
	assign repeat_count = res_q.count;
	assign checksum_ok  = res_q.ok;

endmodule

`default_nettype wire

// File: rtl/core/rsp_packet_deframer_top.sv
// A byte accepted into the input register passes the parser, and its result beat is registered in rspd_out_reg.
// Throughput: one byte per cycle while the result register is free; a byte with no result leaves no beat.
// An untaken result beat stalls the parser, and a byte held in the input register waits.
// Reset is asynchronous and active low; it empties both registers and returns the parser
// to idle with a zero sum, nibble and last byte.
// Top level of the packet deframer; instantiates rspd_parser and rspd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsp_packet_deframer_top
	import rspd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      event_kind,
	output logic [7:0]      data_byte,
	output logic [7:0]      repeat_count,
	output logic            checksum_ok
);

	logic         vld_s1;
	logic [7:0]   byte_s1;
	logic         free;
	logic         step;
	logic         emit;
	rspd_result_t res;

	assign step     = vld_s1 && free;
	assign in_ready = !vld_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	rspd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	rspd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && emit),
		.res          (res),
		.free         (free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.data_byte    (data_byte),
		.repeat_count (repeat_count),
		.checksum_ok  (checksum_ok)
	);

	`ASSERT_CLK(a_s1_hold, vld_s1 && !free |=> vld_s1 && $stable(byte_s1), "Stalled byte lost")
	`ASSERT_CLK(a_stall_full, !in_ready |-> vld_s1 && out_valid && !out_ready, "Bad input stall")
	`ASSERT_CLK(a_end_fields, out_valid && event_kind == EV_END |-> {data_byte, repeat_count} == '0, "End with data")
	`ASSERT_NEVER(a_data_fields, out_valid && event_kind == EV_DATA && (repeat_count == 8'd0 || checksum_ok), "Bad data beat")

endmodule

`default_nettype wire
